@@ src/grid_dda_ray_column_caster_macros.svh @@
// Assertion macros shared by the ray caster checkers.
`ifndef GRID_DDA_RAY_COLUMN_CASTER_MACROS_SVH
`define GRID_DDA_RAY_COLUMN_CASTER_MACROS_SVH

// Assertion that is off while reset is asserted.
`define GDRC_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("gdrc check failed");

// Assertion that is also checked during reset.
`define GDRC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("gdrc check failed");

`endif

@@ src/gdrc_pkg.sv @@
// Types, constants and helper functions of the grid ray caster.
package gdrc_pkg;

  localparam int GRID_SIDE = 16;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int GRID_MAX  = (GRID_SIDE > 16) ? GRID_SIDE : 16;
  localparam int COORD_W   = $clog2(GRID_MAX) + 2;
  localparam int GX_W      = $clog2(GRID_SIDE);
  localparam int IDX_W     = ((ADDR_W > 8) ? ADDR_W : 8) + 1;

  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_W      = 31;
  localparam int DEN_W      = 27;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int CAM_W      = 24;
  localparam int RX_W       = 26;
  localparam int FRAC_W     = 13;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 32;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int SIDE_W     = 58;
  localparam int DIST_W     = 16;
  localparam int LH_W       = 11;

  localparam int ONE_Q14   = 16384;
  localparam int ONE_Q12   = 4096;
  localparam int INF_SHIFT = 52;
  localparam int MIN_DIST  = 3277;
  localparam int SHADE_T0  = 163840;
  localparam int SHADE_T1  = 294912;
  localparam int SHADE_T2  = 491520;

  localparam logic OP_CAST  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE  = 3'd1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CAM_DIV, ST_MUL_RX, ST_MUL_RY, ST_RY_ADD,
    ST_DX_DIV, ST_DY_DIV, ST_MUL_SX, ST_MUL_SY, ST_SY_SET, ST_WALK,
    ST_PROBE, ST_FIN, ST_LH_DIV, ST_DONE
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_X, CFG_POS_Y, CFG_DIR_X, CFG_DIR_Y,
    CFG_PLANE_X, CFG_PLANE_Y, CFG_COLUMN_COUNT, CFG_VIEW_ROWS
  } cfg_idx_t;

  localparam logic [KIND_W-1:0] MAZE [16][16] = '{
    '{3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1},
    '{3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd1},
    '{3'd1,3'd0,3'd2,3'd2,3'd0,3'd0,3'd1,3'd0,3'd3,3'd3,3'd3,3'd0,3'd4,3'd4,3'd0,3'd1},
    '{3'd1,3'd0,3'd2,3'd2,3'd0,3'd0,3'd0,3'd0,3'd3,3'd0,3'd3,3'd0,3'd4,3'd4,3'd0,3'd1},
    '{3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd1,3'd0,3'd3,3'd3,3'd3,3'd0,3'd0,3'd0,3'd0,3'd1},
    '{3'd1,3'd0,3'd1,3'd0,3'd1,3'd0,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd4,3'd0,3'd4,3'd1},
    '{3'd1,3'd0,3'd1,3'd0,3'd1,3'd0,3'd1,3'd1,3'd1,3'd0,3'd1,3'd0,3'd4,3'd0,3'd4,3'd1},
    '{3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd1,3'd0,3'd1,3'd0,3'd0,3'd0,3'd0,3'd1},
    '{3'd1,3'd0,3'd3,3'd0,3'd3,3'd0,3'd0,3'd0,3'd1,3'd0,3'd1,3'd1,3'd1,3'd0,3'd1,3'd1},
    '{3'd1,3'd0,3'd3,3'd0,3'd3,3'd0,3'd2,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd1},
    '{3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd2,3'd0,3'd2,3'd2,3'd0,3'd3,3'd3,3'd3,3'd0,3'd1},
    '{3'd1,3'd0,3'd4,3'd4,3'd4,3'd0,3'd2,3'd0,3'd2,3'd2,3'd0,3'd3,3'd0,3'd3,3'd0,3'd1},
    '{3'd1,3'd0,3'd4,3'd0,3'd4,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd3,3'd3,3'd3,3'd0,3'd1},
    '{3'd1,3'd0,3'd4,3'd4,3'd4,3'd0,3'd1,3'd1,3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd0,3'd1},
    '{3'd1,3'd0,3'd0,3'd0,3'd0,3'd0,3'd1,3'd0,3'd0,3'd0,3'd2,3'd2,3'd2,3'd2,3'd0,3'd1},
    '{3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1}
  };

  // Reset content of a cell: the built-in maze, empty outside its 16x16 corner.
  function automatic logic [KIND_W-1:0] maze_cell(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    logic [KIND_W-1:0] v;
    v = KIND_EMPTY;
    if (x < COORD_W'(16) && y < COORD_W'(16)) begin
      v = MAZE[x[3:0]][y[3:0]];
    end
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
    return ADDR_W'(ADDR_W'(x) * ADDR_W'(GRID_SIDE) + ADDR_W'(y));
  endfunction

endpackage

@@ src/gdrc_if.sv @@
// Valid/ready channel interfaces for cast requests and cast results.
interface gdrc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] column;
  logic [7:0] cell_index;
  logic [2:0] cell_value;
  modport source(output valid, op, column, cell_index, cell_value, input ready);
  modport sink(input valid, op, column, cell_index, cell_value, output ready);
endinterface

interface gdrc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  wall_kind;
  logic        hit_side;
  logic [15:0] wall_distance;
  logic [10:0] line_height;
  logic [1:0]  shade_level;
  modport source(output valid, wall_kind, hit_side, wall_distance, line_height,
                 shade_level, input ready);
  modport sink(input valid, wall_kind, hit_side, wall_distance, line_height,
               shade_level, output ready);
endinterface

@@ src/grid_dda_ray_column_caster.sv @@
// Column ray caster: DDA grid walk over a writable map with one shared divider.
//
// Usage: in_ch carries transactions with op = cast (column) or op = write
// (cell_index, cell_value). A cast returns one result on out_ch; a write
// updates one map cell and returns nothing. Registers are written on cfg_we
// (cfg_idx/cfg_wdata) by the user only while no cast is in flight; unchecked.
//
// Flow: a cast makes four passes of the shared radix-2 divider (camera
// offset, both ray deltas, line height), plus, per grid step, one state to
// step and one for the registered map read.
// One cast is worked on at a time; in_ch.ready is high only while idle.
//
// Reset: the map is reloaded from the built-in maze by a clearing pass of all
// GRID_SIDE*GRID_SIDE cells (256), during which no transaction is accepted;
// registers return to their defaults at once.
//
// Stall: the result sits in an output register, so the next transaction is
// accepted while it waits; a finished cast holds in its last state until
// the output register frees up.
module grid_dda_ray_column_caster (
  input  logic                               clk,
  input  logic                               rst_n,
  gdrc_in_if.sink                            in_ch,
  gdrc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [gdrc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [gdrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  gdrc_pkg::state_t state_r, state_nxt;

  // configuration
  logic        [15:0] pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic        [7:0]  column_count_r;
  logic        [9:0]  view_rows_r;

  // clearing pass
  logic [gdrc_pkg::GX_W-1:0] clr_x_r, clr_y_r;
  logic                      clr_last;

  // shared divider
  logic [gdrc_pkg::NUM_W-1:0] div_quo_r, div_quo_step, div_num;
  logic [gdrc_pkg::DEN_W-1:0] div_rem_r, div_rem_step, div_den_r, div_den;
  logic [gdrc_pkg::DEN_W:0]   div_shift;
  logic [gdrc_pkg::CNT_W-1:0] dcnt_r;
  logic                       div_load, div_run, div_done, div_ge;

  // shared multiplier
  logic signed [gdrc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [gdrc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [gdrc_pkg::MUL_P_W-1:0] mul_p_r;
  logic signed [39:0]                  prod40, prod_adj;

  // ray state
  logic signed [gdrc_pkg::CAM_W-1:0]   cam_r;
  logic signed [gdrc_pkg::RX_W-1:0]    rx_r, ry_r, rx_abs, ry_abs;
  logic        [gdrc_pkg::NUM_W-1:0]   dx_r, dy_r;
  logic        [gdrc_pkg::SIDE_W-1:0]  sx_r, sy_r, dx_ext, dy_ext, d_calc, d_clamp, d_r;
  logic        [gdrc_pkg::SIDE_W-1:0]  q_sum;
  logic signed [gdrc_pkg::COORD_W-1:0] mx_r, my_r, mx_step, my_step, walk_x, walk_y;
  logic        [gdrc_pkg::FRAC_W-1:0]  frac_x, frac_y;
  logic        [gdrc_pkg::KIND_W-1:0]  kind_r;
  logic        [gdrc_pkg::LH_W-1:0]    lh_r, lh_cap;
  logic                                side_r, x_step, walk_in;

  // map
  logic                             ram_we;
  logic [gdrc_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [gdrc_pkg::KIND_W-1:0]      ram_wdata, ram_rdata;
  logic [gdrc_pkg::IDX_W-1:0]       idx_ext;
  logic                             idx_ok;

  // output register
  logic                             out_valid_r, out_load;
  logic [gdrc_pkg::KIND_W-1:0]      out_kind_r;
  logic                             out_side_r;
  logic [gdrc_pkg::DIST_W-1:0]      out_dist_r, dist_q;
  logic [gdrc_pkg::LH_W-1:0]        out_lh_r;
  logic [1:0]                       out_shade_r, shade;

  logic [7:0] cols_eff;

  gdrc_ram #(
    .WIDTH (gdrc_pkg::KIND_W),
    .DEPTH (gdrc_pkg::CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- datapath
  assign clr_last = (clr_x_r == gdrc_pkg::GX_W'(gdrc_pkg::GRID_SIDE - 1)) &&
                    (clr_y_r == gdrc_pkg::GX_W'(gdrc_pkg::GRID_SIDE - 1));

  assign idx_ext = gdrc_pkg::IDX_W'(in_ch.cell_index);
  assign idx_ok  = idx_ext < gdrc_pkg::IDX_W'(gdrc_pkg::CELLS);

  assign cols_eff = (column_count_r == 8'd0) ? 8'd1 : column_count_r;

  // radix-2 restoring division, one quotient bit per cycle
  assign div_shift    = {div_rem_r, div_quo_r[gdrc_pkg::NUM_W-1]};
  assign div_ge       = div_shift >= {1'b0, div_den_r};
  assign div_rem_step = div_ge ? gdrc_pkg::DEN_W'(div_shift - {1'b0, div_den_r})
                               : div_shift[gdrc_pkg::DEN_W-1:0];
  assign div_quo_step = {div_quo_r[gdrc_pkg::NUM_W-2:0], div_ge};
  assign div_run  = (state_r == gdrc_pkg::ST_CAM_DIV) || (state_r == gdrc_pkg::ST_DX_DIV) ||
                    (state_r == gdrc_pkg::ST_DY_DIV)  || (state_r == gdrc_pkg::ST_LH_DIV);
  assign div_done = div_run && (dcnt_r == '0);

  // truncate the plane product toward zero, then scale down by 2^14
  assign prod40   = mul_p_r[39:0];
  assign prod_adj = prod40 + (prod40[39] ? 40'sd16383 : 40'sd0);

  assign rx_abs = rx_r[gdrc_pkg::RX_W-1] ? -rx_r : rx_r;
  assign ry_abs = ry_r[gdrc_pkg::RX_W-1] ? -ry_r : ry_r;

  assign frac_x = rx_r[gdrc_pkg::RX_W-1] ? {1'b0, pos_x_r[11:0]}
                  : gdrc_pkg::FRAC_W'(gdrc_pkg::ONE_Q12) - {1'b0, pos_x_r[11:0]};
  assign frac_y = ry_r[gdrc_pkg::RX_W-1] ? {1'b0, pos_y_r[11:0]}
                  : gdrc_pkg::FRAC_W'(gdrc_pkg::ONE_Q12) - {1'b0, pos_y_r[11:0]};

  // a zero ray component stands for an infinite delta
  assign dx_ext = (rx_r == '0) ? (gdrc_pkg::SIDE_W'(1) << gdrc_pkg::INF_SHIFT)
                               : gdrc_pkg::SIDE_W'(dx_r);
  assign dy_ext = (ry_r == '0) ? (gdrc_pkg::SIDE_W'(1) << gdrc_pkg::INF_SHIFT)
                               : gdrc_pkg::SIDE_W'(dy_r);

  assign x_step  = sx_r < sy_r;
  assign mx_step = rx_r[gdrc_pkg::RX_W-1] ? mx_r - gdrc_pkg::COORD_W'(1)
                                          : mx_r + gdrc_pkg::COORD_W'(1);
  assign my_step = ry_r[gdrc_pkg::RX_W-1] ? my_r - gdrc_pkg::COORD_W'(1)
                                          : my_r + gdrc_pkg::COORD_W'(1);
  assign walk_x  = x_step ? mx_step : mx_r;
  assign walk_y  = x_step ? my_r : my_step;
  assign walk_in = !walk_x[gdrc_pkg::COORD_W-1] && !walk_y[gdrc_pkg::COORD_W-1] &&
                   ($unsigned(walk_x) < gdrc_pkg::COORD_W'(gdrc_pkg::GRID_SIDE)) &&
                   ($unsigned(walk_y) < gdrc_pkg::COORD_W'(gdrc_pkg::GRID_SIDE));

  assign d_calc  = side_r ? sy_r - dy_ext : sx_r - dx_ext;
  assign d_clamp = (d_calc < gdrc_pkg::SIDE_W'(gdrc_pkg::MIN_DIST))
                   ? gdrc_pkg::SIDE_W'(gdrc_pkg::MIN_DIST) : d_calc;

  assign lh_cap = {view_rows_r, 1'b0};

  // round to Q8.8 and saturate
  assign q_sum  = d_r + gdrc_pkg::SIDE_W'(128);
  assign dist_q = (q_sum[gdrc_pkg::SIDE_W-1:24] != '0) ? '1 : q_sum[23:8];
  assign shade  = (d_r < gdrc_pkg::SIDE_W'(gdrc_pkg::SHADE_T0)) ? 2'd0 :
                  (d_r < gdrc_pkg::SIDE_W'(gdrc_pkg::SHADE_T1)) ? 2'd1 :
                  (d_r < gdrc_pkg::SIDE_W'(gdrc_pkg::SHADE_T2)) ? 2'd2 : 2'd3;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gdrc_pkg::ST_CLEAR:   if (clr_last) state_nxt = gdrc_pkg::ST_IDLE;
      gdrc_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.op == gdrc_pkg::OP_CAST) state_nxt = gdrc_pkg::ST_CAM_DIV;
      end
      gdrc_pkg::ST_CAM_DIV: if (div_done) state_nxt = gdrc_pkg::ST_MUL_RX;
      gdrc_pkg::ST_MUL_RX:  state_nxt = gdrc_pkg::ST_MUL_RY;
      gdrc_pkg::ST_MUL_RY:  state_nxt = gdrc_pkg::ST_RY_ADD;
      gdrc_pkg::ST_RY_ADD:  state_nxt = gdrc_pkg::ST_DX_DIV;
      gdrc_pkg::ST_DX_DIV:  if (div_done) state_nxt = gdrc_pkg::ST_DY_DIV;
      gdrc_pkg::ST_DY_DIV:  if (div_done) state_nxt = gdrc_pkg::ST_MUL_SX;
      gdrc_pkg::ST_MUL_SX:  state_nxt = gdrc_pkg::ST_MUL_SY;
      gdrc_pkg::ST_MUL_SY:  state_nxt = gdrc_pkg::ST_SY_SET;
      gdrc_pkg::ST_SY_SET:  state_nxt = gdrc_pkg::ST_WALK;
      gdrc_pkg::ST_WALK:    state_nxt = walk_in ? gdrc_pkg::ST_PROBE : gdrc_pkg::ST_FIN;
      gdrc_pkg::ST_PROBE: begin
        state_nxt = (ram_rdata != gdrc_pkg::KIND_EMPTY) ? gdrc_pkg::ST_FIN : gdrc_pkg::ST_WALK;
      end
      gdrc_pkg::ST_FIN:     state_nxt = gdrc_pkg::ST_LH_DIV;
      gdrc_pkg::ST_LH_DIV:  if (div_done) state_nxt = gdrc_pkg::ST_DONE;
      gdrc_pkg::ST_DONE:    if (out_load) state_nxt = gdrc_pkg::ST_IDLE;
      default:              state_nxt = gdrc_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = gdrc_pkg::cell_addr(gdrc_pkg::COORD_W'(clr_x_r), gdrc_pkg::COORD_W'(clr_y_r));
    ram_wdata   = gdrc_pkg::maze_cell(gdrc_pkg::COORD_W'(clr_x_r),
                                      gdrc_pkg::COORD_W'(clr_y_r));
    ram_raddr   = gdrc_pkg::cell_addr(walk_x, walk_y);
    div_load    = 1'b0;
    div_num     = gdrc_pkg::NUM_W'(1) << 30;
    div_den     = gdrc_pkg::DEN_W'($unsigned(rx_abs));
    mul_a       = '0;
    mul_b       = '0;
    out_load    = 1'b0;
    unique case (state_r)
      gdrc_pkg::ST_CLEAR: ram_we = 1'b1;
      gdrc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_we      = in_ch.valid && in_ch.op == gdrc_pkg::OP_WRITE && idx_ok;
        ram_waddr   = idx_ext[gdrc_pkg::ADDR_W-1:0];
        ram_wdata   = in_ch.cell_value;
        // camera offset numerator: 2 * column * 2^14
        div_load    = in_ch.valid && in_ch.op == gdrc_pkg::OP_CAST;
        div_num     = gdrc_pkg::NUM_W'({in_ch.column, 15'b0});
        div_den     = gdrc_pkg::DEN_W'(cols_eff);
      end
      gdrc_pkg::ST_MUL_RX: begin
        mul_a = gdrc_pkg::MUL_A_W'(cam_r);
        mul_b = gdrc_pkg::MUL_B_W'(plane_x_r);
      end
      gdrc_pkg::ST_MUL_RY: begin
        mul_a = gdrc_pkg::MUL_A_W'(cam_r);
        mul_b = gdrc_pkg::MUL_B_W'(plane_y_r);
      end
      gdrc_pkg::ST_RY_ADD: div_load = 1'b1;
      gdrc_pkg::ST_DX_DIV: begin
        div_load = div_done;
        div_den  = gdrc_pkg::DEN_W'($unsigned(ry_abs));
      end
      gdrc_pkg::ST_MUL_SX: begin
        mul_a = $signed(gdrc_pkg::MUL_A_W'(frac_x));
        mul_b = $signed({1'b0, dx_r});
      end
      gdrc_pkg::ST_MUL_SY: begin
        mul_a = $signed(gdrc_pkg::MUL_A_W'(frac_y));
        mul_b = $signed({1'b0, dy_r});
      end
      gdrc_pkg::ST_FIN: begin
        div_load = 1'b1;
        div_num  = gdrc_pkg::NUM_W'({view_rows_r, 16'b0});
        div_den  = d_clamp[gdrc_pkg::DEN_W-1:0];
      end
      gdrc_pkg::ST_DONE: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.wall_kind     = out_kind_r;
  assign out_ch.hit_side      = out_side_r;
  assign out_ch.wall_distance = out_dist_r;
  assign out_ch.line_height   = out_lh_r;
  assign out_ch.shade_level   = out_shade_r;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= gdrc_pkg::ST_CLEAR;
      clr_x_r        <= '0;
      clr_y_r        <= '0;
      out_valid_r    <= 1'b0;
      pos_x_r        <= 16'd10240;
      pos_y_r        <= 16'd10240;
      dir_x_r        <= 16'sd16384;
      dir_y_r        <= 16'sd0;
      plane_x_r      <= 16'sd0;
      plane_y_r      <= 16'sd10813;
      column_count_r <= 8'd40;
      view_rows_r    <= 10'd21;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (gdrc_pkg::cfg_idx_t'(cfg_idx))
          gdrc_pkg::CFG_POS_X:        pos_x_r        <= cfg_wdata;
          gdrc_pkg::CFG_POS_Y:        pos_y_r        <= cfg_wdata;
          gdrc_pkg::CFG_DIR_X:        dir_x_r        <= $signed(cfg_wdata);
          gdrc_pkg::CFG_DIR_Y:        dir_y_r        <= $signed(cfg_wdata);
          gdrc_pkg::CFG_PLANE_X:      plane_x_r      <= $signed(cfg_wdata);
          gdrc_pkg::CFG_PLANE_Y:      plane_y_r      <= $signed(cfg_wdata);
          gdrc_pkg::CFG_COLUMN_COUNT: column_count_r <= cfg_wdata[7:0];
          gdrc_pkg::CFG_VIEW_ROWS:    view_rows_r    <= cfg_wdata[9:0];
          default: ;
        endcase
      end

      // walk the map row by row while reloading the maze
      if (state_r == gdrc_pkg::ST_CLEAR) begin
        if (clr_y_r == gdrc_pkg::GX_W'(gdrc_pkg::GRID_SIDE - 1)) begin
          clr_y_r <= '0;
          clr_x_r <= clr_x_r + gdrc_pkg::GX_W'(1);
        end else begin
          clr_y_r <= clr_y_r + gdrc_pkg::GX_W'(1);
        end
      end

      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (div_load) begin
      div_quo_r <= div_num;
      div_rem_r <= '0;
      div_den_r <= div_den;
      dcnt_r    <= gdrc_pkg::CNT_W'(gdrc_pkg::NUM_W - 1);
    end else if (div_run) begin
      div_quo_r <= div_quo_step;
      div_rem_r <= div_rem_step;
      dcnt_r    <= dcnt_r - gdrc_pkg::CNT_W'(1);
    end

    mul_p_r <= mul_a * mul_b;

    case (state_r)
      gdrc_pkg::ST_CAM_DIV: begin
        if (div_done) begin
          cam_r <= $signed(div_quo_step[gdrc_pkg::CAM_W-1:0]) -
                   gdrc_pkg::CAM_W'(gdrc_pkg::ONE_Q14);
        end
      end
      gdrc_pkg::ST_MUL_RY: rx_r <= gdrc_pkg::RX_W'(dir_x_r) + $signed(prod_adj[39:14]);
      gdrc_pkg::ST_RY_ADD: ry_r <= gdrc_pkg::RX_W'(dir_y_r) + $signed(prod_adj[39:14]);
      gdrc_pkg::ST_DX_DIV: if (div_done) dx_r <= div_quo_step;
      gdrc_pkg::ST_DY_DIV: if (div_done) dy_r <= div_quo_step;
      gdrc_pkg::ST_MUL_SY: begin
        sx_r <= (rx_r == '0) ? (gdrc_pkg::SIDE_W'(frac_x) << 40)
                             : gdrc_pkg::SIDE_W'(mul_p_r[gdrc_pkg::MUL_P_W-1:12]);
      end
      gdrc_pkg::ST_SY_SET: begin
        sy_r <= (ry_r == '0) ? (gdrc_pkg::SIDE_W'(frac_y) << 40)
                             : gdrc_pkg::SIDE_W'(mul_p_r[gdrc_pkg::MUL_P_W-1:12]);
        mx_r <= gdrc_pkg::COORD_W'(pos_x_r[15:12]);
        my_r <= gdrc_pkg::COORD_W'(pos_y_r[15:12]);
      end
      gdrc_pkg::ST_WALK: begin
        // advance along the axis whose next boundary is nearer
        if (x_step) begin
          sx_r   <= sx_r + dx_ext;
          mx_r   <= mx_step;
          side_r <= 1'b0;
        end else begin
          sy_r   <= sy_r + dy_ext;
          my_r   <= my_step;
          side_r <= 1'b1;
        end
        if (!walk_in) kind_r <= gdrc_pkg::KIND_EDGE;
      end
      gdrc_pkg::ST_PROBE:  kind_r <= ram_rdata;
      gdrc_pkg::ST_FIN:    d_r <= d_clamp;
      gdrc_pkg::ST_LH_DIV: begin
        if (div_done) begin
          if (d_r[gdrc_pkg::SIDE_W-1:gdrc_pkg::DEN_W] != '0) begin
            lh_r <= '0;
          end else if (div_quo_step > gdrc_pkg::NUM_W'(lh_cap)) begin
            lh_r <= lh_cap;
          end else begin
            lh_r <= div_quo_step[gdrc_pkg::LH_W-1:0];
          end
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_kind_r  <= kind_r;
      out_side_r  <= side_r;
      out_dist_r  <= dist_q;
      out_lh_r    <= lh_r;
      out_shade_r <= shade;
    end
  end

endmodule

@@ src/gdrc_ram.sv @@
// Generic simple dual-port RAM with registered read.
module gdrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/gdrc_checker.sv @@
// Port-level checker for the ray caster, bound to the top level.
`include "grid_dda_ray_column_caster_macros.svh"

module gdrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic        out_side,
  input logic [15:0] out_dist,
  input logic [10:0] out_lh,
  input logic [1:0]  out_shade
);
  logic        out_stall;
  logic        in_cast;
  logic        in_write;
  logic [32:0] out_bus;

  assign out_stall = out_valid && !out_ready;
  assign in_cast   = in_valid && in_ready && (in_op == gdrc_pkg::OP_CAST);
  assign in_write  = in_valid && in_ready && (in_op == gdrc_pkg::OP_WRITE);
  assign out_bus   = {out_kind, out_side, out_dist, out_lh, out_shade};

  `GDRC_ASSERT_RST(a_out_hold, clk, rst_n, out_stall |=> out_valid)
  `GDRC_ASSERT_RST(a_out_stable, clk, rst_n, out_stall |=> $stable(out_bus))
  `GDRC_ASSERT_RST(a_cast_busy, clk, rst_n, in_cast |=> !in_ready)
  `GDRC_ASSERT_RST(a_write_silent, clk, rst_n, in_write |=> !$rose(out_valid))
  `GDRC_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !in_ready)
endmodule

bind grid_dda_ray_column_caster gdrc_checker u_gdrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.wall_kind),
  .out_side  (out_ch.hit_side),
  .out_dist  (out_ch.wall_distance),
  .out_lh    (out_ch.line_height),
  .out_shade (out_ch.shade_level)
);
